@@ hw/rtl/ivr_pkg.sv @@
// Package of shared types and constants for the inverse-variance rebinner.
package ivr_pkg;

  localparam int unsigned XW = 24;
  localparam int unsigned YW = 32;
  localparam int unsigned EW = 32;
  localparam int unsigned CW = 4;

  localparam logic [1:0] REG_FOLD8 = 2'd0;
  localparam logic [1:0] REG_FOLD4 = 2'd1;
  localparam logic [1:0] REG_FOLD2 = 2'd2;

  localparam logic [23:0] FOLD8_RST = 24'd104858;
  localparam logic [23:0] FOLD4_RST = 24'd62915;
  localparam logic [23:0] FOLD2_RST = 24'd31457;

  // Operation codes of the shared serial unit.
  typedef enum logic [1:0] {
    OP_DIV,
    OP_SQRT
  } ivr_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ,
    ST_SQ_WAIT,
    ST_WDIV,
    ST_WDIV_WAIT,
    ST_TERM,
    ST_TERM_WAIT,
    ST_ACC,
    ST_MX,
    ST_MX_WAIT,
    ST_MI,
    ST_MI_WAIT,
    ST_ME,
    ST_ME_WAIT,
    ST_RT,
    ST_RT_WAIT
  } ivr_state_e;

  typedef struct packed {
    logic start;
    ivr_op_e op;
  } ivr_ctl_t;

endpackage

@@ hw/rtl/ivr_serial_unit.sv @@
// Shared bit-serial unit: restoring 128/64 division and 64-bit integer square root.
module ivr_serial_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ivr_pkg::ivr_ctl_t ctl_i,
  input  logic [127:0]     num_i,
  input  logic [63:0]      den_i,
  output logic             busy_o,
  output logic [63:0]      res_o
);
  import ivr_pkg::*;

  logic [6:0]   cnt_q, cnt_d;
  logic         busy_q, busy_d;
  ivr_op_e      op_q, op_d;
  logic [64:0]  rem_q, rem_d;
  logic [127:0] num_q, num_d;
  logic [63:0]  den_q, den_d;
  logic [63:0]  res_q, res_d;
  logic [65:0]  trial;
  logic [64:0]  shifted;

  always_comb begin
    cnt_d = cnt_q; busy_d = busy_q; op_d = op_q;
    rem_d = rem_q; num_d = num_q; den_d = den_q; res_d = res_q;
    shifted = '0;
    trial = '0;
    if (ctl_i.start) begin
      busy_d = 1'b1;
      op_d = ctl_i.op;
      den_d = den_i;
      res_d = '0;
      if (ctl_i.op == OP_DIV) begin
        rem_d = {1'b0, num_i[127:64]};
        num_d = {num_i[63:0], 64'd0};
        cnt_d = 7'd64;
      end else begin
        rem_d = '0;
        num_d = num_i;
        cnt_d = 7'd32;
      end
    end else if (busy_q) begin
      if (op_q == OP_DIV) begin
        // One quotient bit each cycle.
        shifted = {rem_q[63:0], num_q[127]};
        trial = {1'b0, shifted} - {2'b00, den_q};
        num_d = {num_q[126:0], 1'b0};
        if (!trial[65]) begin
          rem_d = trial[64:0];
          res_d = {res_q[62:0], 1'b1};
        end else begin
          rem_d = shifted;
          res_d = {res_q[62:0], 1'b0};
        end
      end else begin
        // One root bit each cycle from two radicand bits.
        shifted = {rem_q[62:0], num_q[63:62]};
        trial = {1'b0, shifted} - {2'b00, res_q[61:0], 2'b01};
        num_d = {num_q[127:0] << 2};
        if (!trial[65]) begin
          rem_d = trial[64:0];
          res_d = {res_q[62:0], 1'b1};
        end else begin
          rem_d = shifted;
          res_d = {res_q[62:0], 1'b0};
        end
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
      op_q <= OP_DIV;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
      op_q <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
    den_q <= den_d;
    res_q <= res_d;
  end

  assign busy_o = busy_q | ctl_i.start;
  assign res_o = res_q;
endmodule

@@ hw/rtl/ivr_serial_mult.sv @@
// Shift-and-add multiplier, one multiplier bit per cycle, 64 by 64 bits.
module ivr_serial_mult (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [63:0]   a_i,
  input  logic [63:0]   b_i,
  output logic          busy_o,
  output logic [127:0]  prod_o
);
  logic [6:0]   cnt_q;
  logic [127:0] acc_q;
  logic [127:0] a_q;
  logic [63:0]  b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= 7'd64;
    end else if (cnt_q != 7'd0) begin
      cnt_q <= cnt_q - 7'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      a_q <= {64'd0, a_i};
      b_q <= b_i;
    end else if (cnt_q != 7'd0) begin
      if (b_q[0]) acc_q <= acc_q + a_q;
      a_q <= {a_q[126:0], 1'b0};
      b_q <= {1'b0, b_q[63:1]};
    end
  end

  assign busy_o = start_i | (cnt_q != 7'd0);
  assign prod_o = acc_q;
endmodule

@@ hw/rtl/inverse_variance_rebinner.sv @@
// Top level of the inverse-variance weighted rebinner.
//
//  channel | direction | handshake       | payload
//  --------+-----------+-----------------+----------------------------------------
//  sample  | in        | in_valid/ready  | x_value, y_value, y_error, last_sample
//  bin     | out       | out_valid/ready | mean_x, mean_intensity, mean_error, ...
//  config  | in        | cfg_valid/ready | cfg_index, cfg_data
//
// A sample runs the squared error, the 128/64 weight division and the 64-bit
// term product in turn, each one bit per cycle on the serial units.
// A closing sample adds a further division for mean x, one for the weighted mean
// and one for the weight reciprocal, plus a 32-step square root.
// Reset clears the accumulators and loads the default thresholds; no clearing pass.
// A finished bin waits in the output register; the next sample is taken meanwhile,
// and only a second bin close stalls until the waiting transfer has completed.
module inverse_variance_rebinner #(
  parameter int unsigned MAX_FOLD = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [ivr_pkg::XW-1:0]    x_value_i,
  input  logic signed [ivr_pkg::YW-1:0] y_value_i,
  input  logic [ivr_pkg::EW-1:0]    y_error_i,
  input  logic                      last_sample_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [ivr_pkg::XW-1:0]    mean_x_o,
  output logic signed [ivr_pkg::YW-1:0] mean_intensity_o,
  output logic [ivr_pkg::EW-1:0]    mean_error_o,
  output logic [ivr_pkg::CW-1:0]    bin_count_o,
  output logic                      zero_error_seen_o,
  output logic                      final_bin_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [1:0]                cfg_index_i,
  input  logic [23:0]               cfg_data_i
);
  import ivr_pkg::*;

  localparam logic [CW-1:0] CAP = CW'(MAX_FOLD);

  ivr_state_e state_q, state_d;

  logic [23:0] thr8_q, thr4_q, thr2_q;
  logic [63:0] wsum_q;
  logic signed [63:0] isum_q;
  logic [26:0] xsum_q;
  logic [CW-1:0] cnt_q, target_q;
  logic eflag_q;

  logic [23:0] x_q;
  logic        neg_q, last_q;
  logic [31:0] mag_q, e_q;
  logic [63:0] w_q, e2_q;
  logic [63:0] term_q;
  logic [63:0] q_q;
  logic [23:0] mx_q;

  logic          ov_q;
  logic [23:0]   omx_q;
  logic [31:0]   omi_q, ome_q;
  logic [CW-1:0] ocnt_q;
  logic          oerr_q, ofin_q;

  ivr_ctl_t      su_ctl;
  logic [127:0]  su_num;
  logic [63:0]   su_den, su_res;
  logic          su_busy;
  logic          mu_start, mu_busy;
  logic [63:0]   mu_a, mu_b;
  logic [127:0]  mu_prod;

  logic in_fire;
  logic close;
  logic [CW-1:0] cnt_next;
  logic [CW-1:0] fold;
  logic [64:0] wadd;
  logic [63:0] smag;
  logic signed [64:0] iadd;

  ivr_serial_unit u_su (
    .clk_i, .rst_ni, .ctl_i(su_ctl), .num_i(su_num), .den_i(su_den),
    .busy_o(su_busy), .res_o(su_res)
  );

  ivr_serial_mult u_mu (
    .clk_i, .rst_ni, .start_i(mu_start), .a_i(mu_a), .b_i(mu_b),
    .busy_o(mu_busy), .prod_o(mu_prod)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire = in_valid_i & in_ready_o;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    if (x_value_i > thr8_q) fold = 4'd8;
    else if (x_value_i > thr4_q) fold = 4'd4;
    else if (x_value_i > thr2_q) fold = 4'd2;
    else fold = 4'd1;
    if (32'(fold) > MAX_FOLD) fold = CAP;
  end

  assign cnt_next = cnt_q + 4'd1;
  assign close = (cnt_next >= target_q) | last_q;
  assign smag = isum_q[63] ? (64'd0 - 64'(isum_q)) : 64'(isum_q);
  assign wadd = {1'b0, wsum_q} + {1'b0, w_q};
  assign iadd = {isum_q[63], isum_q} + (neg_q ? -$signed({1'b0, term_q})
                                               : $signed({1'b0, term_q}));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:      if (in_fire) state_d = ST_SQ;
      ST_SQ:        state_d = ST_SQ_WAIT;
      ST_SQ_WAIT:   if (!mu_busy) state_d = ST_WDIV;
      ST_WDIV:      state_d = ST_WDIV_WAIT;
      ST_WDIV_WAIT: if (!su_busy) state_d = ST_TERM;
      ST_TERM:      state_d = ST_TERM_WAIT;
      ST_TERM_WAIT: if (!mu_busy) state_d = ST_ACC;
      ST_ACC:       state_d = close ? ST_MX : ST_IDLE;
      ST_MX:        state_d = ST_MX_WAIT;
      ST_MX_WAIT:   if (!su_busy) state_d = ST_MI;
      ST_MI:        state_d = ST_MI_WAIT;
      ST_MI_WAIT:   if (!su_busy) state_d = ST_ME;
      ST_ME:        state_d = ST_ME_WAIT;
      ST_ME_WAIT:   if (!su_busy) state_d = ST_RT;
      ST_RT:        state_d = ST_RT_WAIT;
      ST_RT_WAIT:   if (!su_busy && (!ov_q || out_ready_i)) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // Unit control.
  always_comb begin
    su_ctl = '{start: 1'b0, op: OP_DIV};
    su_num = '0;
    su_den = '0;
    mu_start = 1'b0;
    mu_a = '0;
    mu_b = '0;
    unique case (state_q)
      ST_SQ: begin
        mu_start = 1'b1; mu_a = {32'd0, e_q}; mu_b = {32'd0, e_q};
      end
      ST_WDIV: begin
        su_ctl.start = (e2_q > 64'd256);
        su_num = {64'd256, 64'd0}; su_den = e2_q;
      end
      ST_TERM: begin
        mu_start = 1'b1; mu_a = {32'd0, mag_q}; mu_b = w_q;
      end
      ST_MX: begin
        su_ctl.start = 1'b1; su_num = {101'd0, xsum_q}; su_den = {60'd0, cnt_q};
      end
      ST_MI: begin
        su_ctl.start = (smag[63:32] < wsum_q);
        su_num = {32'd0, smag, 32'd0}; su_den = wsum_q;
      end
      ST_ME: begin
        su_ctl.start = (wsum_q > 64'd256);
        su_num = {64'd256, 64'd0}; su_den = wsum_q;
      end
      ST_RT: begin
        su_ctl.start = (wsum_q > 64'd256);
        su_ctl.op = OP_SQRT;
        su_num = {64'd0, su_res};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      thr8_q <= FOLD8_RST;
      thr4_q <= FOLD4_RST;
      thr2_q <= FOLD2_RST;
      wsum_q <= '0;
      isum_q <= '0;
      xsum_q <= '0;
      cnt_q <= '0;
      target_q <= '0;
      eflag_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_FOLD8: thr8_q <= cfg_data_i;
          REG_FOLD4: thr4_q <= cfg_data_i;
          REG_FOLD2: thr2_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (ov_q && out_ready_i) ov_q <= 1'b0;
      if (in_fire) begin
        if (target_q == '0) target_q <= fold;
        if (y_error_i == '0) eflag_q <= 1'b1;
      end
      if (state_q == ST_ACC) begin
        wsum_q <= wadd[64] ? '1 : wadd[63:0];
        if (iadd > 65'sh0_7FFF_FFFF_FFFF_FFFF) isum_q <= 64'sh7FFF_FFFF_FFFF_FFFF;
        else if (iadd < -65'sh0_8000_0000_0000_0000) isum_q <= 64'sh8000_0000_0000_0000;
        else isum_q <= iadd[63:0];
        xsum_q <= xsum_q + 27'(x_q);
        cnt_q <= cnt_next;
      end
      if (state_q == ST_RT_WAIT && state_d == ST_IDLE) begin
        ov_q <= 1'b1;
        wsum_q <= '0;
        isum_q <= '0;
        xsum_q <= '0;
        cnt_q <= '0;
        target_q <= '0;
        eflag_q <= 1'b0;
      end
    end
  end

  // Sample payload and result registers. The mean abscissa is staged in mx_q because
  // the serial unit's result is overwritten by the later divisions of the bin.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      x_q <= x_value_i;
      neg_q <= y_value_i[31];
      mag_q <= y_value_i[31] ? (32'd0 - y_value_i) : y_value_i;
      e_q <= y_error_i;
      last_q <= last_sample_i;
    end
    if (state_q == ST_SQ_WAIT && !mu_busy) e2_q <= mu_prod[63:0];
    if (state_q == ST_WDIV_WAIT && !su_busy) w_q <= (e2_q <= 64'd256) ? '1 : su_res;
    if (state_q == ST_TERM_WAIT && !mu_busy)
      term_q <= (mu_prod[127:96] != '0 || mu_prod[95]) ? 64'h7FFF_FFFF_FFFF_FFFF
                                                       : mu_prod[95:32];
    if (state_q == ST_MX_WAIT && !su_busy) mx_q <= su_res[23:0];
    if (state_q == ST_MI_WAIT && !su_busy) q_q <= (smag[63:32] >= wsum_q) ? '1 : su_res;
    if (state_q == ST_RT_WAIT && state_d == ST_IDLE) begin
      omx_q <= mx_q;
      if (isum_q[63]) omi_q <= (q_q >= 64'h8000_0000) ? 32'h8000_0000
                                                       : (32'd0 - q_q[31:0]);
      else omi_q <= (q_q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q_q[31:0];
      ome_q <= (wsum_q <= 64'd256 || su_res[63:32] != '0) ? '1 : su_res[31:0];
      ocnt_q <= cnt_q;
      oerr_q <= eflag_q;
      ofin_q <= last_q;
    end
  end

  assign out_valid_o = ov_q;
  assign mean_x_o = omx_q;
  assign mean_intensity_o = omi_q;
  assign mean_error_o = ome_q;
  assign bin_count_o = ocnt_q;
  assign zero_error_seen_o = oerr_q;
  assign final_bin_o = ofin_q;
endmodule

@@ test/tb.sv @@
// Self-checking testbench for the inverse-variance weighted rebinner.
`timescale 1ns / 1ps

module tb;
  import ivr_pkg::*;

  localparam int unsigned FOLD_LIMIT = 8;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned SETTLE_CYCLES = 600;
  localparam int unsigned RANDOM_PER_PHASE = 215;
  localparam int unsigned HOLD_CYCLES = 3000;
  // Index 3 decodes to no register, so a write to it must be ignored.
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [XW-1:0] mean_x;
    logic [YW-1:0] mean_intensity;
    logic [EW-1:0] mean_error;
    logic [CW-1:0] bin_count;
    logic          zero_error_seen;
    logic          final_bin;
  } bin_result_t;

  // The scoreboard keeps its own copy of the thresholds and of the open bin, and
  // turns every accepted sample into the bin that it closes, if it closes one.
  class bin_board;
    logic [23:0] fold8_thr, fold4_thr, fold2_thr;
    logic [63:0] weight_acc;
    logic [63:0] intensity_acc;
    logic [31:0] x_acc;
    logic [3:0]  sample_cnt;
    logic [3:0]  fold_size;
    logic        zero_seen;
    bin_result_t closed_bins[$];
    int unsigned mismatches;

    function new();
      fold8_thr = FOLD8_RST;
      fold4_thr = FOLD4_RST;
      fold2_thr = FOLD2_RST;
      mismatches = 0;
      open_fresh_bin();
    endfunction

    function void open_fresh_bin();
      weight_acc = '0;
      intensity_acc = '0;
      x_acc = '0;
      sample_cnt = '0;
      fold_size = '0;
      zero_seen = 1'b0;
    endfunction

    function void set_threshold(logic [1:0] idx, logic [23:0] val);
      case (idx)
        REG_FOLD8: fold8_thr = val;
        REG_FOLD4: fold4_thr = val;
        REG_FOLD2: fold2_thr = val;
        default: ;
      endcase
    endfunction

    function logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] root, bitv;
      root = '0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (v >= root + bitv) begin
          v = v - (root + bitv);
          root = (root >> 1) + bitv;
        end else begin
          root = root >> 1;
        end
        bitv = bitv >> 2;
      end
      return root;
    endfunction

    function void note_sample(logic [23:0] x, logic [31:0] y, logic [31:0] e, logic last);
      logic [63:0]  e_sq, w, mag, term, smag, q, me;
      logic [64:0]  wsum;
      logic [127:0] prod;
      logic signed [65:0] acc;
      logic [31:0]  mi;
      logic         neg, sneg;
      bin_result_t  res;
      if (fold_size == 0) begin
        if (x > fold8_thr) fold_size = 4'd8;
        else if (x > fold4_thr) fold_size = 4'd4;
        else if (x > fold2_thr) fold_size = 4'd2;
        else fold_size = 4'd1;
        if (fold_size > FOLD_LIMIT) fold_size = 4'(FOLD_LIMIT);
      end
      e_sq = {32'b0, e} * {32'b0, e};
      // Very small errors would give a weight of 2^64 or more: pin it to all ones.
      if (e_sq <= 64'd256) w = '1;
      else w = 64'((128'd1 << 72) / {64'b0, e_sq});
      if (e == 0) zero_seen = 1'b1;
      wsum = {1'b0, weight_acc} + {1'b0, w};
      weight_acc = wsum[64] ? '1 : wsum[63:0];

      neg = y[31];
      mag = neg ? {32'b0, (~y) + 32'd1} : {32'b0, y};
      prod = {64'b0, mag} * {64'b0, w};
      term = (prod[127:32] > 96'h7FFF_FFFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF_FFFF : prod[95:32];
      acc = $signed({{2{intensity_acc[63]}}, intensity_acc});
      if (neg) acc = acc - $signed({2'b0, term});
      else acc = acc + $signed({2'b0, term});
      if (acc[65:63] == 3'b000 || acc[65:63] == 3'b111) intensity_acc = acc[63:0];
      else intensity_acc = acc[65] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;

      x_acc = x_acc + {8'b0, x};
      sample_cnt = sample_cnt + 4'd1;
      if (sample_cnt < fold_size && !last) return;

      sneg = intensity_acc[63];
      smag = sneg ? (64'd0 - intensity_acc) : intensity_acc;
      if ((smag >> 32) >= weight_acc) q = '1;
      else q = 64'(({64'b0, smag} << 32) / {64'b0, weight_acc});
      if (sneg) mi = (q >= 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - q[31:0]);
      else mi = (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
      if (weight_acc <= 64'd256) me = 64'hFFFF_FFFF;
      else me = int_sqrt(64'((128'd1 << 72) / {64'b0, weight_acc}));
      if (me > 64'hFFFF_FFFF) me = 64'hFFFF_FFFF;

      res.mean_x = 24'(x_acc / {28'b0, sample_cnt});
      res.mean_intensity = mi;
      res.mean_error = me[31:0];
      res.bin_count = sample_cnt;
      res.zero_error_seen = zero_seen;
      res.final_bin = last;
      closed_bins.insert(closed_bins.size(), res);
      open_fresh_bin();
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      mismatches++;
      $display("%0t: bin mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    endtask

    task check_bin(bin_result_t got);
      bin_result_t want;
      if (closed_bins.size() == 0) begin
        report("unexpected bin", 64'(got), 64'd0);
        return;
      end
      want = closed_bins.pop_front();
      if (got.mean_x !== want.mean_x) report("mean_x", got.mean_x, want.mean_x);
      if (got.mean_intensity !== want.mean_intensity)
        report("mean_intensity", got.mean_intensity, want.mean_intensity);
      if (got.mean_error !== want.mean_error)
        report("mean_error", got.mean_error, want.mean_error);
      if (got.bin_count !== want.bin_count)
        report("bin_count", got.bin_count, want.bin_count);
      if (got.zero_error_seen !== want.zero_error_seen)
        report("zero_error_seen", got.zero_error_seen, want.zero_error_seen);
      if (got.final_bin !== want.final_bin)
        report("final_bin", got.final_bin, want.final_bin);
    endtask
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [XW-1:0]     x_value_i = '0;
  logic signed [YW-1:0] y_value_i = '0;
  logic [EW-1:0]     y_error_i = '0;
  logic              last_sample_i = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [XW-1:0]     mean_x_o;
  logic signed [YW-1:0] mean_intensity_o;
  logic [EW-1:0]     mean_error_o;
  logic [CW-1:0]     bin_count_o;
  logic              zero_error_seen_o;
  logic              final_bin_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [1:0]        cfg_index_i = '0;
  logic [23:0]       cfg_data_i = '0;

  bin_board board = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        recv_hold = 1'b0;
  int unsigned quiet_cycles = 0;

  inverse_variance_rebinner #(.MAX_FOLD(FOLD_LIMIT)) DUT (.*);

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // The receiver stalls at random, and all the time while a long hold-off is running.
  always @(posedge clk_i) begin
    out_ready_i <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  // Every completed output transfer is checked against the oldest predicted bin.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      board.check_bin('{mean_x_o, mean_intensity_o, mean_error_o, bin_count_o,
                        zero_error_seen_o, final_bin_o});
    end
  end

  // The watchdog ends the run when no channel has moved a transfer for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("** inverse_variance_rebinner: FAILED **");
        $finish;
      end
    end
  end

  // Called at a rising edge; returns at the edge on which the sample was taken,
  // leaving valid high so that a following sample can follow without a gap.
  task send_sample(logic [23:0] x, logic [31:0] y, logic [31:0] e, logic last);
    if (in_valid_i && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    x_value_i <= x;
    y_value_i <= y;
    y_error_i <= e;
    last_sample_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_sample(x, y, e, last);
  endtask

  task write_threshold(logic [1:0] idx, logic [23:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    board.set_threshold(idx, val);
  endtask

  // Waits until every predicted bin has been seen, then gives the block time to
  // finish a sample that closes no bin.
  task drain_and_settle();
    in_valid_i <= 1'b0;
    while (board.closed_bins.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function logic [23:0] pick_abscissa();
    logic [24:0] near;
    case ($urandom_range(5))
      0: return 24'd0;
      1: return 24'hFFFFFF;
      2: begin
        case ($urandom_range(2))
          0: near = {1'b0, board.fold8_thr};
          1: near = {1'b0, board.fold4_thr};
          default: near = {1'b0, board.fold2_thr};
        endcase
        near = near + 25'($urandom_range(2)) - 25'd1;
        return near[24] ? (near[23] ? 24'd0 : 24'hFFFFFF) : near[23:0];
      end
      3: return 24'($urandom_range(120000));
      default: return 24'($urandom);
    endcase
  endfunction

  function logic [31:0] pick_error();
    case ($urandom_range(7))
      0: return 32'd0;
      1: return 32'($urandom_range(1, 17));
      2: return 32'hFFFF_FFFF - 32'($urandom_range(3));
      3: return 32'($urandom_range(18, 4096));
      4: return 32'($urandom_range(32'h0000_4000, 32'h0004_0000));
      default: return $urandom;
    endcase
  endfunction

  function logic [31:0] pick_intensity();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'($signed($urandom_range(65536 * 4)) - 131072);
      default: return $urandom;
    endcase
  endfunction

  task run_directed();
    // A single-sample bin at the lowest abscissa.
    send_sample(24'd0, 32'd0, 32'h0001_0000, 1'b0);
    // An eight-sample bin, flushed early by the last sample: zero and tiny errors
    // saturate both sums, and the error exactly at the weight limit is covered.
    send_sample(24'hFFFFFF, 32'h7FFF_FFFF, 32'd0, 1'b0);
    send_sample(24'd1, 32'h8000_0000, 32'd1, 1'b0);
    send_sample(24'd500000, 32'h7FFF_FFFF, 32'd16, 1'b0);
    send_sample(24'd7, 32'h0001_0000, 32'd17, 1'b0);
    send_sample(24'hFFFFFF, 32'hFFFF_0000, 32'hFFFF_FFFF, 1'b0);
    send_sample(24'd80000, 32'h7FFF_FFFF, 32'd300, 1'b0);
    send_sample(24'd3, 32'h1234_5678, 32'h0000_0100, 1'b1);
    // A four-sample bin with a large negative mean.
    send_sample(24'd70000, 32'h8000_0000, 32'h0000_0800, 1'b0);
    send_sample(24'd0, 32'h8000_0000, 32'h0000_0800, 1'b0);
    send_sample(24'hFFFFFF, 32'h8000_0001, 32'h0000_1000, 1'b0);
    send_sample(24'd62915, 32'h8000_0000, 32'h0000_0800, 1'b0);
    // A two-sample bin opened just above its threshold.
    send_sample(24'd31458, 32'h0000_8000, 32'h0002_0000, 1'b0);
    send_sample(24'd31457, 32'hFFFF_8000, 32'h0003_0000, 1'b0);
    // The largest error alone leaves the weight sum too small for a reciprocal.
    send_sample(24'd0, 32'h0000_0001, 32'hFFFF_FFFF, 1'b1);
    // A zero error on its own in a single-sample bin.
    send_sample(24'd31457, 32'h0000_0000, 32'd0, 1'b0);
  endtask

  task run_random(int unsigned count);
    logic [23:0] x;
    int unsigned left_in_set;
    left_in_set = $urandom_range(4, 40);
    for (int unsigned n = 0; n < count; n++) begin
      x = pick_abscissa();
      left_in_set--;
      send_sample(x, pick_intensity(), pick_error(), left_in_set == 0);
      if (left_in_set == 0) left_in_set = $urandom_range(1, 40);
    end
  endtask

  initial begin
    logic [23:0] t_a, t_b, t_c;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int phase = 0; phase < 6; phase++) begin
      // Idling pattern cycles: receiver sparse, then sender sparse, then none.
      case (phase % 3)
        0: begin send_idle_pct = 23; recv_idle_pct = 60; end
        1: begin send_idle_pct = 60; recv_idle_pct = 23; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      // Threshold settings: reset values, all zero, all ones, then random ones.
      case (phase)
        0: ;
        1: begin t_a = 24'd0; t_b = 24'd0; t_c = 24'd0; end
        2: begin t_a = 24'hFFFFFF; t_b = 24'hFFFFFF; t_c = 24'hFFFFFF; end
        default: begin
          t_c = 24'($urandom_range(20000, 60000));
          t_b = t_c + 24'($urandom_range(60000));
          t_a = t_b + 24'($urandom_range(200000));
        end
      endcase
      if (phase != 0) begin
        write_threshold(REG_FOLD8, t_a);
        write_threshold(REG_FOLD4, t_b);
        write_threshold(REG_FOLD2, t_c);
        write_threshold(REG_UNUSED, 24'($urandom));
        @(posedge clk_i);
      end
      if (phase == 0) run_directed();
      if (phase == 2) begin
        // Hold the receiver off while samples keep coming, so the block backs up.
        fork
          begin
            recv_hold = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk_i);
            recv_hold = 1'b0;
          end
        join_none
      end
      run_random(RANDOM_PER_PHASE);
      drain_and_settle();
    end

    if (board.mismatches == 0 && board.closed_bins.size() == 0) begin
      $display("** inverse_variance_rebinner: PASSED **");
    end else begin
      $display("** inverse_variance_rebinner: FAILED **");
    end
    $finish;
  end

endmodule
